/* design/rrt_pkg.sv */
// types and codes shared by the resource table and its checker
// no dependencies
package rrt_pkg;

  typedef enum logic [2:0] {
    KIND_ADD     = 3'd0,
    KIND_RELEASE = 3'd1,
    KIND_DELETE  = 3'd2,
    KIND_QUERY   = 3'd3,
    KIND_FLUSH   = 3'd4,
    KIND_EMPTY   = 3'd5
  } kind_e;

  typedef enum logic [3:0] {
    ST_ADDED       = 4'd0,
    ST_INCREMENTED = 4'd1,
    ST_DECREMENTED = 4'd2,
    ST_DELETED     = 4'd3,
    ST_FOUND       = 4'd4,
    ST_NOT_FOUND   = 4'd5,
    ST_FULL        = 4'd6,
    ST_RELEASED    = 4'd7,
    ST_NOTHING     = 4'd8
  } status_e;

  localparam int MaxOut = 64;
  localparam logic signed [15:0] CountMax = 16'sh7fff;
  localparam logic signed [15:0] CountMin = -16'sh8000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] key;
    logic [7:0]  type_code;
    logic [31:0] handle;
  } req_t;

  typedef struct packed {
    logic [3:0]         status;
    logic [5:0]         slot;
    logic signed [15:0] ref_count;
    logic [31:0]        out_handle;
    logic [7:0]         out_type;
    logic               last;
  } res_t;

  typedef struct packed {
    logic [31:0]        key;
    logic [7:0]         etype;
    logic [31:0]        ehandle;
    logic signed [15:0] ecount;
  } entry_t;

endpackage

/* design/refcounted_resource_table.sv */
// Reference-counted resource table, top level: sequencer around rrt_mem.
// Depends on rrt_pkg and rrt_mem.
//
// One command at a time; busy is high while a command runs. Lookups walk the
// active entries through the single read port at one entry per cycle.
// Results appear as one-cycle strobes on res_valid_o, the receiver cannot
// stall them, and the final word of a command carries last and comes in
// the cycle in which busy drops.
// No clearing pass after reset.
module refcounted_resource_table #(
  parameter int ENTRIES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rrt_pkg::req_t req_i,
  output logic          busy,
  output logic          res_valid_o,
  output rrt_pkg::res_t res_o
);
  import rrt_pkg::*;

  localparam int IW = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOOK  = 10'b0000000010,
    S_MISS  = 10'b0000000100,
    S_DMOV  = 10'b0000001000,
    S_FSCAN = 10'b0000010000,
    S_FCHK  = 10'b0000100000,
    S_FMOV  = 10'b0001000000,
    S_ESCAN = 10'b0010000000,
    S_ECHK  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] active_q, active_d, cnt_q, cnt_d, base_q, base_d;
  logic [6:0] k_q, k_d;
  req_t req_q, req_d;
  res_t pend_q, res_q;
  logic pend_v_q, res_valid_q;

  logic rd_en, wr_en;
  logic [IW-1:0] rd_addr, wr_addr;
  entry_t rd_data, wr_data, e_mod;
  logic push;
  res_t push_res;
  res_t fin_res;

  rrt_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  function automatic res_t mk_res(status_e st, logic [CW-1:0] idx, entry_t e);
    res_t r;
    r.status     = st;
    r.slot       = 6'(idx);
    r.ref_count  = e.ecount;
    r.out_handle = e.ehandle;
    r.out_type   = e.etype;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_empty(status_e st);
    res_t r;
    r        = '0;
    r.status = st;
    return r;
  endfunction

  always_comb begin
    state_d  = state_q;
    active_d = active_q;
    cnt_d    = cnt_q;
    base_d   = base_q;
    k_d      = k_q;
    req_d    = req_q;
    rd_en    = 1'b0;
    rd_addr  = cnt_q[IW-1:0];
    wr_en    = 1'b0;
    wr_addr  = cnt_q[IW-1:0];
    wr_data  = rd_data;
    push     = 1'b0;
    push_res = '0;
    e_mod    = rd_data;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          req_d = req_i;
          cnt_d = '0;
          k_d   = '0;
          case (req_i.kind)
            KIND_ADD, KIND_RELEASE, KIND_DELETE, KIND_QUERY: begin
              if (active_q == '0) begin
                state_d = S_MISS;
              end else begin
                rd_en   = 1'b1;
                rd_addr = '0;
                state_d = S_LOOK;
              end
            end
            KIND_FLUSH: state_d = S_FSCAN;
            KIND_EMPTY: begin
              if (int'(active_q) > MaxOut) begin
                base_d = CW'(int'(active_q) - MaxOut);
              end else begin
                base_d = '0;
              end
              cnt_d   = base_d;
              state_d = S_ESCAN;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_LOOK: begin
        if (rd_data.key == req_q.key) begin
          state_d = S_FIN;
          push    = 1'b1;
          case (req_q.kind)
            KIND_ADD: begin
              if (rd_data.ecount != CountMax) e_mod.ecount = rd_data.ecount + 16'sd1;
              wr_en    = 1'b1;
              wr_data  = e_mod;
              push_res = mk_res(ST_INCREMENTED, cnt_q, e_mod);
            end
            KIND_RELEASE: begin
              if (rd_data.ecount != CountMin) e_mod.ecount = rd_data.ecount - 16'sd1;
              wr_en    = 1'b1;
              wr_data  = e_mod;
              push_res = mk_res(ST_DECREMENTED, cnt_q, e_mod);
            end
            KIND_DELETE: begin
              push_res = mk_res(ST_DELETED, cnt_q, rd_data);
              active_d = active_q - CW'(1);
              rd_en    = 1'b1;
              rd_addr  = active_d[IW-1:0];
              state_d  = S_DMOV;
            end
            default: push_res = mk_res(ST_FOUND, cnt_q, rd_data);
          endcase
        end else if ((cnt_q + CW'(1)) < active_q) begin
          cnt_d   = cnt_q + CW'(1);
          rd_en   = 1'b1;
          rd_addr = cnt_d[IW-1:0];
        end else begin
          state_d = S_MISS;
        end
      end
      S_MISS: begin
        push    = 1'b1;
        state_d = S_FIN;
        if (req_q.kind == KIND_ADD) begin
          if (int'(active_q) >= ENTRIES) begin
            push_res = mk_empty(ST_FULL);
          end else begin
            e_mod.key     = req_q.key;
            e_mod.etype   = req_q.type_code;
            e_mod.ehandle = req_q.handle;
            e_mod.ecount  = 16'sd1;
            wr_en         = 1'b1;
            wr_addr       = active_q[IW-1:0];
            wr_data       = e_mod;
            push_res      = mk_res(ST_ADDED, active_q, e_mod);
            active_d      = active_q + CW'(1);
          end
        end else begin
          push_res = mk_empty(ST_NOT_FOUND);
        end
      end
      S_DMOV: begin
        wr_en   = 1'b1;
        state_d = S_FIN;
      end
      S_FSCAN: begin
        if (cnt_q < active_q && k_q < 7'(MaxOut)) begin
          rd_en   = 1'b1;
          state_d = S_FCHK;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FCHK: begin
        if ((rd_data.ecount[15] || rd_data.ecount == 16'sd0) && rd_data.etype != 8'd0) begin
          push     = 1'b1;
          push_res = mk_res(ST_RELEASED, cnt_q, rd_data);
          k_d      = k_q + 7'd1;
          active_d = active_q - CW'(1);
          rd_en    = 1'b1;
          rd_addr  = active_d[IW-1:0];
          state_d  = S_FMOV;
        end else begin
          cnt_d   = cnt_q + CW'(1);
          state_d = S_FSCAN;
        end
      end
      S_FMOV: begin
        wr_en   = 1'b1;
        state_d = S_FSCAN;
      end
      S_ESCAN: begin
        if (cnt_q < active_q) begin
          rd_en   = 1'b1;
          state_d = S_ECHK;
        end else begin
          active_d = base_q;
          state_d  = S_FIN;
        end
      end
      S_ECHK: begin
        push     = 1'b1;
        push_res = mk_res(ST_RELEASED, cnt_q, rd_data);
        cnt_d    = cnt_q + CW'(1);
        state_d  = S_ESCAN;
      end
      S_FIN: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // final word of a command
  always_comb begin
    fin_res      = pend_v_q ? pend_q : mk_empty(ST_NOTHING);
    fin_res.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      cnt_q       <= '0;
      base_q      <= '0;
      k_q         <= '0;
      pend_v_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      cnt_q       <= cnt_d;
      base_q      <= base_d;
      k_q         <= k_d;
      res_valid_q <= (push && pend_v_q) || (state_q == S_FIN);
      if (push) begin
        pend_v_q <= 1'b1;
      end else if (state_q == S_FIN) begin
        pend_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    if (push) begin
      pend_q <= push_res;
      res_q  <= pend_q;
    end else if (state_q == S_FIN) begin
      res_q <= fin_res;
    end
  end

  assign busy        = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
endmodule

/* design/rrt_mem.sv */
// entry storage: one write port, one registered read port
// depends on rrt_pkg
module rrt_mem #(
  parameter int ENTRIES = 64
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr_i,
  output rrt_pkg::entry_t            rd_data_o,
  input  logic                       wr_en_i,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr_i,
  input  rrt_pkg::entry_t            wr_data_i
);
  import rrt_pkg::*;

  entry_t mem [ENTRIES];
  entry_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;
endmodule

/* design/rrt_checker.sv */
// port-level checks for the resource table, bound to the top level
// depends on rrt_pkg and refcounted_resource_table
module rrt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input rrt_pkg::req_t req_i,
  input logic          busy,
  input logic          res_valid_o,
  input rrt_pkg::res_t res_o
);
  import rrt_pkg::*;

  a_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.kind <= KIND_EMPTY |=> busy)
    else $error("valid command did not raise busy");

  a_mid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !res_o.last |-> busy)
    else $error("non-final word outside a command");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_o && res_o.last)
    else $error("command ended without final word");

  a_last_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.last |=> !res_valid_o)
    else $error("word right after final word");

  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.status <= ST_NOTHING)
    else $error("status code out of range");
endmodule

bind refcounted_resource_table rrt_checker u_rrt_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .start      (start),
  .req_i      (req_i),
  .busy       (busy),
  .res_valid_o(res_valid_o),
  .res_o      (res_o)
);
